[src/rtc_snapshot_to_epoch_defines.svh]
// assertion macros shared by the rtc snapshot converter
`ifndef RTC_SNAPSHOT_TO_EPOCH_DEFINES_SVH
`define RTC_SNAPSHOT_TO_EPOCH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RTCSE_ASSERT_HOLDS(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error("rtcse check failed");

// next-cycle implication, disabled during reset
`define RTCSE_ASSERT_NEXT(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error("rtcse check failed");

`endif

[src/rtcse_pkg.sv]
// types, constants and calendar tables of the rtc snapshot converter
package rtcse_pkg;

  localparam int STB_BINARY_BIT = 2;
  localparam int STB_H24_BIT    = 1;
  localparam int HOUR_PM_BIT    = 7;

  localparam int EPOCH_YEAR     = 1970;
  localparam int MAX_YEAR       = 9999;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int LEAPS_TO_EPOCH = 477;
  localparam int SEC_PER_DAY    = 86400;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int SEC_PER_MIN    = 60;
  localparam int NOON_HOUR      = 12;

  localparam logic [6:0] DEF_CENTURY = 7'd20;

  // floor(y / 100) = (y * RECIP100) >> RECIP100_SHIFT, exact for y < 2**15
  localparam int RECIP100       = 5243;
  localparam int RECIP100_SHIFT = 19;
  // floor(v / 7) = (v * RECIP7) >> RECIP7_SHIFT, exact for v < 13110
  localparam int RECIP7         = 9363;
  localparam int RECIP7_SHIFT   = 16;

  localparam int YEAR_W  = 15;
  localparam int QY_W    = 9;
  localparam int DAYS_W  = 22;
  localparam int TOD_W   = 19;
  localparam int WS_W    = 16;
  localparam int WQ_W    = 14;
  localparam int EPOCH_W = 38;

  typedef enum logic [0:0] {
    REG_USE_CENTURY = 1'b0,
    REG_DEF_CENTURY = 1'b1
  } cfg_reg_t;

  // decoded snapshot, first stage
  typedef struct packed {
    logic       valid;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] yy;
    logic [7:0] cen;
  } dec_t;

  // full year and time of day
  typedef struct packed {
    logic              valid;
    logic [5:0]        sec;
    logic [5:0]        min;
    logic [4:0]        hr;
    logic [7:0]        day;
    logic [7:0]        mon;
    logic [YEAR_W-1:0] year;
    logic [TOD_W-1:0]  tod;
    logic              mon_ok;
    logic              early;
  } ymd_t;

  // calendar record leaving the day-count stages
  typedef struct packed {
    logic              valid;
    logic [5:0]        sec;
    logic [5:0]        min;
    logic [4:0]        hr;
    logic [4:0]        day;
    logic [3:0]        mon;
    logic [13:0]       year;
    logic              err;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
    logic [WS_W-1:0]   ws;
    logic [WQ_W-1:0]   wq;
  } cal_t;

  function automatic logic [7:0] bcd8(input logic [7:0] v);
    logic [7:0] tens;
    tens = {4'b0, v[7:4]};
    return {4'b0, v[3:0]} + (tens << 3) + (tens << 1);
  endfunction

  function automatic logic [4:0] mon_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2: d = 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1: d = 9'd0;
      4'd2: d = 9'd31;
      4'd3: d = 9'd59;
      4'd4: d = 9'd90;
      4'd5: d = 9'd120;
      4'd6: d = 9'd151;
      4'd7: d = 9'd181;
      4'd8: d = 9'd212;
      4'd9: d = 9'd243;
      4'd10: d = 9'd273;
      4'd11: d = 9'd304;
      4'd12: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] sak_off(input logic [3:0] m);
    logic [2:0] d;
    case (m)
      4'd1: d = 3'd0;
      4'd2: d = 3'd3;
      4'd3: d = 3'd2;
      4'd4: d = 3'd5;
      4'd5: d = 3'd0;
      4'd6: d = 3'd3;
      4'd7: d = 3'd5;
      4'd8: d = 3'd1;
      4'd9: d = 3'd4;
      4'd10: d = 3'd6;
      4'd11: d = 3'd2;
      4'd12: d = 3'd4;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

[src/rtcse_decode.sv]
// bcd and hour decode, century select, full year and time of day
module rtcse_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        raw_second,
  input  logic [7:0]        raw_minute,
  input  logic [7:0]        raw_hour,
  input  logic [7:0]        raw_day,
  input  logic [7:0]        raw_month,
  input  logic [7:0]        raw_year,
  input  logic [7:0]        raw_century,
  input  logic [7:0]        status_b,
  input  logic              use_century,
  input  logic [6:0]        def_century,
  output rtcse_pkg::ymd_t   ymd
);

  rtcse_pkg::dec_t dec_next;
  rtcse_pkg::dec_t dec;
  rtcse_pkg::ymd_t ymd_next;

  logic       binary;
  logic       pm;
  logic [7:0] hr_dec;
  logic [7:0] cen_dec;

  always_comb begin
    binary = status_b[rtcse_pkg::STB_BINARY_BIT];
    pm     = raw_hour[rtcse_pkg::HOUR_PM_BIT];
    if (binary) begin
      dec_next.sec = raw_second;
      dec_next.min = raw_minute;
      hr_dec       = {1'b0, raw_hour[6:0]};
      dec_next.day = raw_day;
      dec_next.mon = raw_month;
      dec_next.yy  = raw_year;
      cen_dec      = raw_century;
    end else begin
      dec_next.sec = rtcse_pkg::bcd8(raw_second);
      dec_next.min = rtcse_pkg::bcd8(raw_minute);
      hr_dec       = rtcse_pkg::bcd8({1'b0, raw_hour[6:0]});
      dec_next.day = rtcse_pkg::bcd8(raw_day);
      dec_next.mon = rtcse_pkg::bcd8(raw_month);
      dec_next.yy  = rtcse_pkg::bcd8(raw_year);
      cen_dec      = rtcse_pkg::bcd8(raw_century);
    end
    // 12-hour to 24-hour form
    dec_next.hr = hr_dec;
    if (!status_b[rtcse_pkg::STB_H24_BIT]) begin
      if (hr_dec == 8'(rtcse_pkg::NOON_HOUR)) begin
        dec_next.hr = 8'd0;
      end
      if (pm) begin
        dec_next.hr = dec_next.hr + 8'(rtcse_pkg::NOON_HOUR);
      end
    end
    dec_next.cen   = use_century ? cen_dec : {1'b0, def_century};
    dec_next.valid = take;
  end

  always_comb begin
    ymd_next.valid  = dec.valid;
    ymd_next.sec    = dec.sec[5:0];
    ymd_next.min    = dec.min[5:0];
    ymd_next.hr     = dec.hr[4:0];
    ymd_next.day    = dec.day;
    ymd_next.mon    = dec.mon;
    ymd_next.year   = rtcse_pkg::YEAR_W'(dec.cen) * rtcse_pkg::YEAR_W'(100)
                    + rtcse_pkg::YEAR_W'(dec.yy);
    ymd_next.tod    = rtcse_pkg::TOD_W'(dec.hr) * rtcse_pkg::TOD_W'(rtcse_pkg::SEC_PER_HOUR)
                    + rtcse_pkg::TOD_W'(dec.min) * rtcse_pkg::TOD_W'(rtcse_pkg::SEC_PER_MIN)
                    + rtcse_pkg::TOD_W'(dec.sec);
    ymd_next.mon_ok = (dec.mon >= 8'd1) && (dec.mon <= 8'd12);
    ymd_next.early  = (dec.mon < 8'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
      ymd.valid <= 1'b0;
    end else begin
      dec.valid <= dec_next.valid;
      ymd.valid <= ymd_next.valid;
    end
    dec.sec    <= dec_next.sec;
    dec.min    <= dec_next.min;
    dec.hr     <= dec_next.hr;
    dec.day    <= dec_next.day;
    dec.mon    <= dec_next.mon;
    dec.yy     <= dec_next.yy;
    dec.cen    <= dec_next.cen;
    ymd.sec    <= ymd_next.sec;
    ymd.min    <= ymd_next.min;
    ymd.hr     <= ymd_next.hr;
    ymd.day    <= ymd_next.day;
    ymd.mon    <= ymd_next.mon;
    ymd.year   <= ymd_next.year;
    ymd.tod    <= ymd_next.tod;
    ymd.mon_ok <= ymd_next.mon_ok;
    ymd.early  <= ymd_next.early;
  end

endmodule

[src/rtcse_days.sv]
// date check, leap year, day count since epoch and weekday sum
module rtcse_days (
  input  logic            clk,
  input  logic            rst,
  input  rtcse_pkg::ymd_t ymd,
  output rtcse_pkg::cal_t cal
);

  localparam int YW = rtcse_pkg::YEAR_W;
  localparam int QW = rtcse_pkg::QY_W;
  localparam int DW = rtcse_pkg::DAYS_W;
  localparam int SW = rtcse_pkg::WS_W;

  // stage c: century quotients and year offset
  logic              c_valid;
  logic [5:0]        c_sec;
  logic [5:0]        c_min;
  logic [4:0]        c_hr;
  logic [7:0]        c_day;
  logic [7:0]        c_mon;
  logic [13:0]       c_year;
  logic [YW-1:0]     c_ym1;
  logic [YW-1:0]     c_yw;
  logic [QW-1:0]     c_q1;
  logic [QW-1:0]     c_qw;
  logic [DW-1:0]     c_yoff;
  logic              c_err;
  logic [rtcse_pkg::TOD_W-1:0] c_tod;

  logic [YW-1:0]     ym1_next;
  logic [YW-1:0]     yw_next;
  logic [27:0]       prod1;
  logic [27:0]       prodw;

  always_comb begin
    ym1_next = ymd.year - YW'(1);
    yw_next  = ymd.year - YW'(ymd.early);
    prod1    = 28'(ym1_next) * 28'(rtcse_pkg::RECIP100);
    prodw    = 28'(yw_next) * 28'(rtcse_pkg::RECIP100);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= ymd.valid;
    end
  end

  always_ff @(posedge clk) begin
    c_sec  <= ymd.sec;
    c_min  <= ymd.min;
    c_hr   <= ymd.hr;
    c_day  <= ymd.day;
    c_mon  <= ymd.mon;
    c_tod  <= ymd.tod;
    c_year <= (ymd.year > YW'(rtcse_pkg::MAX_YEAR)) ? 14'(rtcse_pkg::MAX_YEAR)
                                                     : ymd.year[13:0];
    c_ym1  <= ym1_next;
    c_yw   <= yw_next;
    c_q1   <= prod1[rtcse_pkg::RECIP100_SHIFT +: QW];
    c_qw   <= prodw[rtcse_pkg::RECIP100_SHIFT +: QW];
    c_yoff <= (DW'(ymd.year) - DW'(rtcse_pkg::EPOCH_YEAR)) * DW'(rtcse_pkg::DAYS_PER_YEAR);
    c_err  <= (ymd.year < YW'(rtcse_pkg::EPOCH_YEAR)) ||
              (ymd.year > YW'(rtcse_pkg::MAX_YEAR)) || !ymd.mon_ok;
  end

  // stage d: leap year, day check, leap count and weekday sum
  logic              d_valid;
  logic [5:0]        d_sec;
  logic [5:0]        d_min;
  logic [4:0]        d_hr;
  logic [4:0]        d_day;
  logic [3:0]        d_mon;
  logic [13:0]       d_year;
  logic              d_err;
  logic [DW-1:0]     d_yoff;
  logic [DW-1:0]     d_leaps;
  logic [8:0]        d_cum;
  logic              d_leap_add;
  logic [SW-1:0]     d_ws;
  logic [rtcse_pkg::TOD_W-1:0] d_tod;

  logic [YW-1:0]     rem100;
  logic              leap;
  logic [3:0]        m4;
  logic [4:0]        dim;
  logic              day_bad;

  always_comb begin
    m4      = c_mon[3:0];
    rem100  = c_ym1 - YW'(c_q1) * YW'(100);
    // year = ym1 + 1: divisible by 4 when ym1 ends in 3 mod 4, by 100 when rem is 99
    leap    = (c_ym1[1:0] == 2'd3) && ((rem100 != YW'(99)) || (c_q1[1:0] == 2'd3));
    dim     = rtcse_pkg::mon_days(m4) + 5'((m4 == 4'd2) && leap);
    day_bad = (c_day == 8'd0) || (c_day > {3'b0, dim});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_sec      <= c_sec;
    d_min      <= c_min;
    d_hr       <= c_hr;
    d_day      <= c_day[4:0];
    d_mon      <= m4;
    d_year     <= c_year;
    d_tod      <= c_tod;
    d_err      <= c_err || day_bad;
    d_yoff     <= c_yoff;
    d_leaps    <= DW'(c_ym1 >> 2) - DW'(c_q1) + DW'(c_q1 >> 2)
                - DW'(rtcse_pkg::LEAPS_TO_EPOCH);
    d_cum      <= rtcse_pkg::cum_days(m4);
    d_leap_add <= (m4 > 4'd2) && leap;
    d_ws       <= SW'(c_yw) + SW'(c_yw >> 2) - SW'(c_qw) + SW'(c_qw >> 2)
                + SW'(rtcse_pkg::sak_off(m4)) + SW'(c_day);
  end

  // stage e: day count and weekday quotient
  logic [29:0] wprod;

  always_comb begin
    wprod = 30'(d_ws) * 30'(rtcse_pkg::RECIP7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.valid <= 1'b0;
    end else begin
      cal.valid <= d_valid;
    end
    cal.sec  <= d_sec;
    cal.min  <= d_min;
    cal.hr   <= d_hr;
    cal.day  <= d_day;
    cal.mon  <= d_mon;
    cal.year <= d_year;
    cal.err  <= d_err;
    cal.tod  <= d_tod;
    cal.ws   <= d_ws;
    cal.days <= d_yoff + d_leaps + DW'(d_cum) + DW'(d_leap_add) + DW'(d_day) - DW'(1);
    cal.wq   <= wprod[rtcse_pkg::RECIP7_SHIFT +: rtcse_pkg::WQ_W];
  end

endmodule

[src/rtcse_scale.sv]
// day count to seconds, weekday remainder and the output register
module rtcse_scale (
  input  logic            clk,
  input  logic            rst,
  input  rtcse_pkg::cal_t cal,
  output logic            done,
  output logic [5:0]      sec_out,
  output logic [5:0]      min_out,
  output logic [4:0]      hour_out,
  output logic [4:0]      day_out,
  output logic [3:0]      month_out,
  output logic [13:0]     full_year,
  output logic [2:0]      weekday,
  output logic [37:0]     epoch_seconds,
  output logic            date_error
);

  localparam int EW = rtcse_pkg::EPOCH_W;
  localparam int SW = rtcse_pkg::WS_W;

  // stage f
  logic          f_valid;
  logic [5:0]    f_sec;
  logic [5:0]    f_min;
  logic [4:0]    f_hr;
  logic [4:0]    f_day;
  logic [3:0]    f_mon;
  logic [13:0]   f_year;
  logic          f_err;
  logic [EW-1:0] f_day_sec;
  logic [rtcse_pkg::TOD_W-1:0] f_tod;
  logic [2:0]    f_wday;
  logic [SW-1:0] wrem;

  always_comb begin
    wrem = cal.ws - SW'(cal.wq) * SW'(7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= cal.valid;
    end
  end

  always_ff @(posedge clk) begin
    f_sec     <= cal.sec;
    f_min     <= cal.min;
    f_hr      <= cal.hr;
    f_day     <= cal.day;
    f_mon     <= cal.mon;
    f_year    <= cal.year;
    f_err     <= cal.err;
    f_tod     <= cal.tod;
    f_day_sec <= EW'(cal.days) * EW'(rtcse_pkg::SEC_PER_DAY);
    f_wday    <= wrem[2:0];
  end

  // stage g: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    sec_out       <= f_sec;
    min_out       <= f_min;
    hour_out      <= f_hr;
    day_out       <= f_day;
    month_out     <= f_mon;
    full_year     <= f_year;
    date_error    <= f_err;
    weekday       <= f_err ? 3'd0 : f_wday;
    epoch_seconds <= f_err ? '0 : (f_day_sec + EW'(f_tod));
  end

`include "rtc_snapshot_to_epoch_defines.svh"

  `RTCSE_ASSERT_HOLDS(a_wday_range, clk, rst, f_valid && !f_err, f_wday < 3'd7)

endmodule

[src/rtc_snapshot_to_epoch.sv]
// top level of the rtc snapshot converter: configuration registers and pipeline
// Converts one snapshot of CMOS clock registers into calendar fields, a
// weekday and seconds since 1970-01-01 00:00:00.
// A request is taken at a rising edge with start high and busy low; busy is
// high only while rst is held, so a new snapshot can be taken every cycle.
// Each request gives one result: done is high for exactly one cycle with the
// result fields, after seven register stages (decode, year, quotients,
// leap/check, day count, scale, output).
// Throughput is one snapshot per cycle; results leave in request order.
// The receiver cannot hold results off, and the pipeline never stalls.
// Configuration: wr_en with wr_index selects use_century_byte (index 0) or
// default_century (index 1), written from wr_data at that edge. Write it only
// when no request is in flight.
// date_error flags a year outside 1970..9999 or a bad month or day; then
// epoch_seconds and weekday are zero and full_year saturates at 9999.
// Reset clears all valid bits and sets use_century_byte to 0 and
// default_century to 20; requests in flight are dropped.
module rtc_snapshot_to_epoch (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  raw_second,
  input  logic [7:0]  raw_minute,
  input  logic [7:0]  raw_hour,
  input  logic [7:0]  raw_day,
  input  logic [7:0]  raw_month,
  input  logic [7:0]  raw_year,
  input  logic [7:0]  raw_century,
  input  logic [7:0]  status_b,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [6:0]  wr_data,
  output logic        done,
  output logic [5:0]  sec_out,
  output logic [5:0]  min_out,
  output logic [4:0]  hour_out,
  output logic [4:0]  day_out,
  output logic [3:0]  month_out,
  output logic [13:0] full_year,
  output logic [2:0]  weekday,
  output logic [37:0] epoch_seconds,
  output logic        date_error
);

  logic            use_century;
  logic [6:0]      def_century;
  logic            take;
  rtcse_pkg::ymd_t ymd;
  rtcse_pkg::cal_t cal;

  assign busy = rst;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_century <= 1'b0;
      def_century <= rtcse_pkg::DEF_CENTURY;
    end else if (wr_en) begin
      case (wr_index)
        rtcse_pkg::REG_USE_CENTURY: use_century <= wr_data[0];
        rtcse_pkg::REG_DEF_CENTURY: def_century <= wr_data;
        default: ;
      endcase
    end
  end

  rtcse_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .raw_second  (raw_second),
    .raw_minute  (raw_minute),
    .raw_hour    (raw_hour),
    .raw_day     (raw_day),
    .raw_month   (raw_month),
    .raw_year    (raw_year),
    .raw_century (raw_century),
    .status_b    (status_b),
    .use_century (use_century),
    .def_century (def_century),
    .ymd         (ymd)
  );

  rtcse_days u_days (
    .clk (clk),
    .rst (rst),
    .ymd (ymd),
    .cal (cal)
  );

  rtcse_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .cal           (cal),
    .done          (done),
    .sec_out       (sec_out),
    .min_out       (min_out),
    .hour_out      (hour_out),
    .day_out       (day_out),
    .month_out     (month_out),
    .full_year     (full_year),
    .weekday       (weekday),
    .epoch_seconds (epoch_seconds),
    .date_error    (date_error)
  );

`include "rtc_snapshot_to_epoch_defines.svh"

  `RTCSE_ASSERT_NEXT(a_latency, clk, rst, take, ##6 done)
  `RTCSE_ASSERT_HOLDS(a_err_zero, clk, rst, done && date_error,
                      epoch_seconds == 38'd0 && weekday == 3'd0)
  `RTCSE_ASSERT_HOLDS(a_year_sat, clk, rst, done, full_year <= 14'd9999)

endmodule

[test/rtc_snapshot_to_epoch_tb.sv]
// self-checking testbench for the rtc snapshot to epoch converter
module rtc_snapshot_to_epoch_tb;

  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LIMIT_CYCLES  = 200000;
  // weekday offset per month, january in the low nibble
  localparam logic [47:0] WEEKDAY_OFS =
    {4'd4, 4'd2, 4'd6, 4'd4, 4'd1, 4'd5, 4'd3, 4'd0, 4'd5, 4'd2, 4'd3, 4'd0};

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
    logic [7:0] status;
  } snap_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  wday;
    logic [37:0] epoch;
    logic        err;
  } calendar_t;

  typedef enum logic [1:0] {OP_SNAPSHOT, OP_CONFIG, OP_HOLD} op_kind_t;

  typedef struct {
    op_kind_t              kind;
    snap_t                 snap;
    rtcse_pkg::cfg_reg_t   idx;
    logic [6:0]            data;
    int                    gap;
  } snap_op_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  snap_t               drive_snap = '0;
  logic                wr_en = 1'b0;
  rtcse_pkg::cfg_reg_t wr_index = rtcse_pkg::REG_USE_CENTURY;
  logic [6:0]          wr_data = '0;
  logic                done;
  logic [5:0]          sec_out;
  logic [5:0]          min_out;
  logic [4:0]          hour_out;
  logic [4:0]          day_out;
  logic [3:0]          month_out;
  logic [13:0]         full_year;
  logic [2:0]          weekday;
  logic [37:0]         epoch_seconds;
  logic                date_error;

  snap_op_t    snapshot_ops[$];
  calendar_t   calendar_due[$];
  logic        req_taken = 1'b0;
  int          gap_left = 0;
  int          quiet_cycles = 0;
  logic        cfg_use = 1'b0;
  logic [6:0]  cfg_cent = rtcse_pkg::DEF_CENTURY;
  int          mismatches = 0;
  int          results_checked = 0;
  int          flagged_dates = 0;
  int          cfg_writes = 0;

  rtc_snapshot_to_epoch dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .raw_second(drive_snap.sec),
    .raw_minute(drive_snap.min),
    .raw_hour(drive_snap.hour),
    .raw_day(drive_snap.day),
    .raw_month(drive_snap.month),
    .raw_year(drive_snap.year),
    .raw_century(drive_snap.century),
    .status_b(drive_snap.status),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .sec_out(sec_out),
    .min_out(min_out),
    .hour_out(hour_out),
    .day_out(day_out),
    .month_out(month_out),
    .full_year(full_year),
    .weekday(weekday),
    .epoch_seconds(epoch_seconds),
    .date_error(date_error)
  );

  function automatic int unsigned bcd_value(input logic [7:0] v);
    return v[3:0] + 10 * v[7:4];
  endfunction

  function automatic bit is_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned leaps_through(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic calendar_t to_calendar(input snap_t s, input bit use_cen,
                                            input logic [6:0] cent);
    calendar_t c;
    int unsigned sec, mins, hr, day, mon, yy, cen, year, days, y, wd, m;
    longint unsigned secs;
    bit pm, err;
    pm = s.hour[rtcse_pkg::HOUR_PM_BIT];
    if (!s.status[rtcse_pkg::STB_BINARY_BIT]) begin
      sec  = bcd_value(s.sec);
      mins = bcd_value(s.min);
      hr   = s.hour[3:0] + 10 * s.hour[6:4];
      day  = bcd_value(s.day);
      mon  = bcd_value(s.month);
      yy   = bcd_value(s.year);
      cen  = bcd_value(s.century);
    end else begin
      sec  = s.sec;
      mins = s.min;
      hr   = s.hour[6:0];
      day  = s.day;
      mon  = s.month;
      yy   = s.year;
      cen  = s.century;
    end
    if (!s.status[rtcse_pkg::STB_H24_BIT]) begin
      if (hr == rtcse_pkg::NOON_HOUR) hr = 0;
      if (pm) hr += 12;
    end
    year = (use_cen ? cen : int'(cent)) * 100 + yy;
    err = year < rtcse_pkg::EPOCH_YEAR || year > rtcse_pkg::MAX_YEAR || mon < 1 || mon > 12;
    if (!err && (day < 1 || day > month_days(mon, year))) err = 1'b1;
    secs = 0;
    wd = 0;
    if (!err) begin
      days = rtcse_pkg::DAYS_PER_YEAR * (year - rtcse_pkg::EPOCH_YEAR)
           + leaps_through(year - 1) - leaps_through(rtcse_pkg::EPOCH_YEAR - 1);
      for (m = 1; m < mon; m++) days += month_days(m, year);
      days += day - 1;
      secs = days;
      secs = secs * rtcse_pkg::SEC_PER_DAY + hr * rtcse_pkg::SEC_PER_HOUR
           + mins * rtcse_pkg::SEC_PER_MIN + sec;
      y = year - ((mon < 3) ? 1 : 0);
      wd = (y + y / 4 - y / 100 + y / 400 + WEEKDAY_OFS[(mon - 1) * 4 +: 4] + day) % 7;
    end
    if (year > rtcse_pkg::MAX_YEAR) year = rtcse_pkg::MAX_YEAR;
    c.sec   = 6'(sec);
    c.min   = 6'(mins);
    c.hour  = 5'(hr);
    c.day   = 5'(day);
    c.month = 4'(mon);
    c.year  = 14'(year);
    c.wday  = 3'(wd);
    c.epoch = 38'(secs);
    c.err   = err;
    return c;
  endfunction

  function automatic logic [7:0] encode_digits(input int unsigned v, input bit binary);
    return binary ? 8'(v) : {4'(v / 10), 4'(v % 10)};
  endfunction

  // mostly well-formed snapshots, some broken dates, some raw noise
  function automatic snap_t random_snapshot(input bit use_cen, input int unsigned cent);
    snap_t s;
    bit binary, h24, pm;
    int unsigned kind, c, yy, year, mon, day, dim, hr24, h12;
    kind = $urandom_range(0, 99);
    s = {$urandom, $urandom};
    if (kind >= 88) return s;
    binary = $urandom_range(0, 1);
    h24 = $urandom_range(0, 1);
    s.status[rtcse_pkg::STB_BINARY_BIT] = binary;
    s.status[rtcse_pkg::STB_H24_BIT] = h24;
    if (!use_cen) c = cent;
    else if ($urandom_range(0, 3) == 0) c = $urandom_range(19, 99);
    else c = $urandom_range(19, 21);
    yy = $urandom_range(0, 99);
    year = c * 100 + yy;
    mon = $urandom_range(1, 12);
    dim = month_days(mon, year);
    day = ($urandom_range(0, 4) == 0) ? dim : $urandom_range(1, dim);
    if (kind >= 72) begin
      case ($urandom_range(0, 2))
        0: day = dim + 1;
        1: mon = $urandom_range(0, 1) ? 0 : 13;
        default: day = 0;
      endcase
    end
    hr24 = $urandom_range(0, 23);
    pm = hr24 >= 12;
    h12 = (hr24 % 12 == 0) ? 12 : hr24 % 12;
    s.sec   = encode_digits($urandom_range(0, 59), binary);
    s.min   = encode_digits($urandom_range(0, 59), binary);
    s.hour  = encode_digits(h24 ? hr24 : h12, binary);
    s.hour[rtcse_pkg::HOUR_PM_BIT] = h24 ? 1'($urandom_range(0, 1)) : pm;
    s.day   = encode_digits(day, binary);
    s.month = encode_digits(mon, binary);
    s.year  = encode_digits(yy, binary);
    if (use_cen) s.century = encode_digits(c, binary);
    return s;
  endfunction

  function automatic int draw_gap(input bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_snapshot(input snap_t s, input bit no_gaps);
    snap_op_t op;
    op.kind = OP_SNAPSHOT;
    op.snap = s;
    op.idx  = rtcse_pkg::REG_USE_CENTURY;
    op.data = '0;
    op.gap  = draw_gap(no_gaps);
    snapshot_ops.push_back(op);
  endtask

  task automatic queue_write(input rtcse_pkg::cfg_reg_t idx, input logic [6:0] data);
    snap_op_t op;
    op.kind = OP_CONFIG;
    op.snap = '0;
    op.idx  = idx;
    op.data = data;
    op.gap  = 0;
    snapshot_ops.push_back(op);
  endtask

  task automatic queue_hold();
    snap_op_t op;
    op.kind = OP_HOLD;
    op.snap = '0;
    op.idx  = rtcse_pkg::REG_USE_CENTURY;
    op.data = '0;
    op.gap  = 0;
    snapshot_ops.push_back(op);
  endtask

  // every third stretch of 20 has no gaps, the others are gappy; one full drain midway
  task automatic queue_random(input bit use_cen, input int unsigned cent, input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) queue_hold();
      queue_snapshot(random_snapshot(use_cen, cent), (i / 20) % 3 == 1);
    end
  endtask

  task automatic check_field(input string field, input logic [37:0] want, input logic [37:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("FAIL rtc_snapshot_to_epoch");
    $finish;
  end

  // driver
  always @(negedge clk) begin
    snap_op_t            head;
    logic                nx_start, nx_wr;
    rtcse_pkg::cfg_reg_t nx_idx;
    logic [6:0]          nx_data;
    snap_t               nx_snap;
    nx_start = start;
    nx_wr    = 1'b0;
    nx_idx   = wr_index;
    nx_data  = wr_data;
    nx_snap  = drive_snap;
    if (rst) begin
      nx_start = 1'b0;
    end else begin
      if (calendar_due.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;
      if (!start || req_taken) begin
        nx_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (snapshot_ops.size() != 0) begin
          head = snapshot_ops[0];
          case (head.kind)
            OP_SNAPSHOT: begin
              nx_snap  = head.snap;
              nx_start = 1'b1;
              gap_left = head.gap;
              void'(snapshot_ops.pop_front());
            end
            OP_CONFIG: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                nx_wr   = 1'b1;
                nx_idx  = head.idx;
                nx_data = head.data;
                void'(snapshot_ops.pop_front());
              end
            end
            default: begin
              if (calendar_due.size() == 0) void'(snapshot_ops.pop_front());
            end
          endcase
        end
      end
    end
    start      <= nx_start;
    wr_en      <= nx_wr;
    wr_index   <= nx_idx;
    wr_data    <= nx_data;
    drive_snap <= nx_snap;
  end

  // monitor and checker
  always @(posedge clk) begin
    calendar_t want;
    if (rst) begin
      req_taken <= 1'b0;
      cfg_use   <= 1'b0;
      cfg_cent  <= rtcse_pkg::DEF_CENTURY;
    end else begin
      req_taken <= start && !busy;
      if (wr_en) begin
        cfg_writes++;
        case (wr_index)
          rtcse_pkg::REG_USE_CENTURY: cfg_use <= wr_data[0];
          rtcse_pkg::REG_DEF_CENTURY: cfg_cent <= wr_data;
          default: ;
        endcase
      end
      if (done) begin
        if (calendar_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no request outstanding");
        end else begin
          want = calendar_due.pop_front();
          check_field("sec_out", want.sec, sec_out);
          check_field("min_out", want.min, min_out);
          check_field("hour_out", want.hour, hour_out);
          check_field("day_out", want.day, day_out);
          check_field("month_out", want.month, month_out);
          check_field("full_year", want.year, full_year);
          check_field("weekday", want.wday, weekday);
          check_field("epoch_seconds", want.epoch, epoch_seconds);
          check_field("date_error", want.err, date_error);
          results_checked++;
          if (want.err) flagged_dates++;
        end
      end
      if (start && !busy) calendar_due.push_back(to_calendar(drive_snap, cfg_use, cfg_cent));
    end
  end

  initial begin
    int unsigned mid_cent;
    // default century 20, bcd 24-hour unless noted
    queue_snapshot({8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h00, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h31, 8'h12, 8'h99, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h01, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h50, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h50, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h50, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h50, 8'h00, 8'h02}, 0);
    // 12-hour mode: midnight, noon, afternoon
    queue_snapshot({8'h30, 8'h15, 8'h12, 8'h15, 8'h06, 8'h24, 8'h00, 8'h00}, 0);
    queue_snapshot({8'h30, 8'h15, 8'h92, 8'h15, 8'h06, 8'h24, 8'h00, 8'h00}, 0);
    queue_snapshot({8'h30, 8'h15, 8'h81, 8'h15, 8'h06, 8'h24, 8'h00, 8'h00}, 0);
    // pm flag ignored in 24-hour mode
    queue_snapshot({8'h30, 8'h15, 8'h95, 8'h15, 8'h06, 8'h24, 8'h00, 8'h02}, 0);
    // binary mode
    queue_snapshot({8'h3B, 8'h3B, 8'h17, 8'h1F, 8'h0C, 8'h63, 8'h00, 8'h06}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h8C, 8'h01, 8'h01, 8'h00, 8'h00, 8'h04}, 0);
    // non-bcd nibbles and all-ones / all-zero snapshots
    queue_snapshot({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 0);
    queue_snapshot({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
    queue_random(1'b0, 20, 80);

    queue_write(rtcse_pkg::REG_DEF_CENTURY, 7'd19);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h00, 8'h02}, 0);
    queue_snapshot({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h00, 8'h02}, 0);
    queue_random(1'b0, 19, 80);

    // century from the snapshot
    queue_write(rtcse_pkg::REG_USE_CENTURY, 7'd1);
    queue_snapshot({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h64, 8'h06}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h21, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h24, 8'h02}, 0);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'hFF, 8'h02}, 0);
    queue_random(1'b1, 19, 80);

    queue_write(rtcse_pkg::REG_USE_CENTURY, 7'd0);
    queue_write(rtcse_pkg::REG_DEF_CENTURY, 7'd99);
    queue_snapshot({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h02}, 0);
    queue_random(1'b0, 99, 80);

    mid_cent = $urandom_range(21, 98);
    queue_write(rtcse_pkg::REG_DEF_CENTURY, 7'(mid_cent));
    queue_random(1'b0, mid_cent, 80);

    while (snapshot_ops.size() != 0 || start || calendar_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d conversions, %0d of them flagged as bad dates", results_checked,
             flagged_dates);
    $display("%0d register writes across five century settings, %0d mismatches", cfg_writes,
             mismatches);
    if (mismatches == 0 && calendar_due.size() == 0) begin
      $display("PASS rtc_snapshot_to_epoch");
    end else begin
      $display("FAIL rtc_snapshot_to_epoch");
    end
    $finish;
  end

endmodule

[rtc_snapshot_to_epoch.f]
+incdir+src
src/rtcse_pkg.sv
src/rtcse_decode.sv
src/rtcse_days.sv
src/rtcse_scale.sv
src/rtc_snapshot_to_epoch.sv
test/rtc_snapshot_to_epoch_tb.sv
